// ===== hw/rtl/pca_pkg.sv =====
// Shared types and constants for the palette color allocator.
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    localparam int MAX_PLANES  = 8;
    localparam int TABLE_DEPTH = 1 << MAX_PLANES;
    localparam int IDX_W       = MAX_PLANES;
    localparam int CNT_W       = MAX_PLANES + 1;
    localparam int RGB_W       = 48;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_PIXEL  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLANE_MASKS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PLANE_COUNT = 2'd2;

    typedef struct packed {
        logic        is_transparent;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] image_index;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  pixel_value;
        logic        opaque;
        logic [15:0] transparent_index;
        logic        new_cell;
    } t_res;

    // token, first-hit flag and hit position handed cell to cell
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_link;

endpackage

`default_nettype wire

// ===== hw/rtl/pca_cell.sv =====
// One color table entry with its compare stage in the search chain.
`timescale 1ns / 1ps
`default_nettype none

module pca_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [pca_pkg::IDX_W-1:0] i_pos,
    input  wire [pca_pkg::CNT_W-1:0] i_count,
    input  wire [pca_pkg::RGB_W-1:0] i_key,
    input  wire                      i_wr_en,
    input  pca_pkg::t_link           i_link,
    output pca_pkg::t_link           o_link
);
    import pca_pkg::*;

    logic [RGB_W-1:0] r_entry;
    t_link            r_link;
    t_link            n_link;
    logic             w_live;
    logic             w_match;

    assign w_live  = {1'b0, i_pos} < i_count;
    assign w_match = i_link.tok && !i_link.hit && w_live && (r_entry == i_key);

    always_comb begin
        n_link     = i_link;
        n_link.hit = i_link.hit || w_match;
        if (w_match) begin
            n_link.idx = i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
            r_link.hit <= 1'b0;
        end else begin
            r_link.tok <= n_link.tok;
            r_link.hit <= n_link.hit;
        end
        r_link.idx <= n_link.idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_key;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ===== hw/rtl/palette_color_allocator.sv =====
// Top level of the palette color allocator: config, sequencer and cell chain.
`timescale 1ns / 1ps
`default_nettype none

// A transparent request gives its result in the cycle after the transfer and
// leaves busy low. An opaque request sends a search token down a chain of
// TABLE_DEPTH (256) entry cells, one cell per cycle, and its result appears
// after the token leaves the last cell, with busy high until the
// result is shown. A new request may be started in the cycle the result is
// shown. Each result is on o_res for one cycle under o_res_valid and is not
// held: the receiver must take it then.
module palette_color_allocator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  pca_pkg::t_req                 i_req,
    output logic                          o_res_valid,
    output pca_pkg::t_res                 o_res,
    input  wire                           i_cfg_we,
    input  wire [pca_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [pca_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pca_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state           r_state;
    logic             r_inject;
    logic [CNT_W-1:0] r_count;
    logic             r_res_valid;
    t_res             r_res;
    t_res             n_res;
    logic [RGB_W-1:0] r_key;

    logic [7:0]       r_base_pixel;
    logic [63:0]      r_plane_masks;
    logic [3:0]       r_plane_count;

    t_link            w_link [TABLE_DEPTH+1];
    logic             w_accept;
    logic [3:0]       w_planes;
    logic [CNT_W-1:0] w_cap;
    logic             w_full;
    logic             w_done;
    logic             w_append;
    logic             w_emit;

    function automatic logic [7:0] f_compose(input logic [7:0]       base,
                                             input logic [63:0]      masks,
                                             input logic [IDX_W-1:0] idx);
        logic [7:0] px;
        px = base;
        for (int j = 0; j < IDX_W; j++) begin
            if (idx[j]) begin
                px = px | masks[8*j +: 8];
            end
        end
        return px;
    endfunction

    assign busy     = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept = start && !busy;

    assign w_planes = (r_plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : r_plane_count;
    assign w_cap    = CNT_W'(1) << w_planes;
    assign w_full   = r_count >= w_cap;

    assign w_done   = (r_state == S_SCAN) && w_link[TABLE_DEPTH].tok;
    assign w_append = w_done && !w_link[TABLE_DEPTH].hit && !w_full;
    assign w_emit   = (w_accept && i_req.is_transparent) || w_done;

    always_comb begin
        n_res = '0;
        if (r_state == S_IDLE) begin
            n_res.transparent_index = i_req.image_index;
        end else if (w_link[TABLE_DEPTH].hit) begin
            n_res.opaque      = 1'b1;
            n_res.pixel_value = f_compose(r_base_pixel, r_plane_masks,
                                          w_link[TABLE_DEPTH].idx);
        end else if (w_full) begin
            n_res.status = 1'b1;
        end else begin
            n_res.opaque      = 1'b1;
            n_res.new_cell    = 1'b1;
            n_res.pixel_value = f_compose(r_base_pixel, r_plane_masks,
                                          r_count[IDX_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pixel  <= '0;
            r_plane_masks <= '0;
            r_plane_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_PIXEL:  r_base_pixel  <= i_cfg_data[7:0];
                CFG_PLANE_MASKS: r_plane_masks <= i_cfg_data;
                CFG_PLANE_COUNT: r_plane_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= {i_req.red, i_req.green, i_req.blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
            r_res       <= '0;
        end else begin
            r_inject    <= w_accept && !i_req.is_transparent;
            r_res_valid <= w_emit;
            if (w_emit) begin
                r_res <= n_res;
            end
            if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && !i_req.is_transparent) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_link[0].tok = r_inject;
    assign w_link[0].hit = 1'b0;
    assign w_link[0].idx = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        pca_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (IDX_W'(g)),
            .i_count (r_count),
            .i_key   (r_key),
            .i_wr_en (w_append && (r_count[IDX_W-1:0] == IDX_W'(g))),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/pca_checker.sv =====
// Port-level checks for the palette color allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pca_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           start,
    input wire           busy,
    input pca_pkg::t_req i_req,
    input wire           o_res_valid,
    input pca_pkg::t_res o_res
);
    import pca_pkg::*;

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status) |-> (!o_res.new_cell && !o_res.opaque))
        else $error("full result carries cell data");

    a_transp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.opaque) |-> (o_res.pixel_value == 8'd0 && !o_res.new_cell))
        else $error("non-opaque result carries pixel or new cell");

    a_transp_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.is_transparent) |=>
        (o_res_valid && !o_res.opaque && o_res.transparent_index == $past(i_req.image_index)))
        else $error("transparent transfer not answered next cycle");

    a_opaque_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req.is_transparent) |=> (busy && !o_res_valid))
        else $error("opaque transfer did not start a search");

endmodule

bind palette_color_allocator pca_checker u_pca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire

// ===== verif/palette_color_allocator_test.sv =====
// Self-checking testbench for the palette color allocator: predicts every result and compares it.
`timescale 1ns / 1ps

module palette_color_allocator_test;
    import pca_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 11;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    class color_cell_tracker;
        logic [7:0]       base_pixel;
        logic [63:0]      plane_masks;
        logic [3:0]       plane_count;
        logic [RGB_W-1:0] cells [TABLE_DEPTH];
        int               cell_count;
        t_res             awaited [$];
        int               errors;
        int               n_requests;
        int               n_transparent;
        int               n_new;
        int               n_match;
        int               n_full;
        int               n_settings;

        function new();
            base_pixel    = '0;
            plane_masks   = '0;
            plane_count   = '0;
            cell_count    = 0;
            errors        = 0;
            n_requests    = 0;
            n_transparent = 0;
            n_new         = 0;
            n_match       = 0;
            n_full        = 0;
            n_settings    = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                CFG_BASE_PIXEL:  base_pixel  = data[7:0];
                CFG_PLANE_MASKS: plane_masks = data;
                CFG_PLANE_COUNT: plane_count = data[3:0];
                default: ;
            endcase
            n_settings++;
        endfunction

        function int capacity();
            int n;
            n = int'(plane_count);
            if (n > MAX_PLANES) n = MAX_PLANES;
            return 1 << n;
        endfunction

        function logic [7:0] compose_pixel(logic [IDX_W-1:0] idx);
            logic [7:0] px;
            px = base_pixel;
            for (int j = 0; j < MAX_PLANES; j++)
                if (idx[j]) px |= plane_masks[8*j +: 8];
            return px;
        endfunction

        function void note_request(t_req r);
            t_res             want;
            logic [RGB_W-1:0] rgb;
            int               hit;
            want = '0;
            n_requests++;
            if (r.is_transparent) begin
                want.transparent_index = r.image_index;
                n_transparent++;
            end else begin
                rgb = {r.red, r.green, r.blue};
                hit = -1;
                for (int i = 0; i < cell_count; i++)
                    if (hit < 0 && cells[i] == rgb) hit = i;
                if (hit >= 0) begin
                    n_match++;
                end else if (cell_count >= capacity()) begin
                    want.status = 1'b1;
                    n_full++;
                end else begin
                    cells[cell_count] = rgb;
                    hit = cell_count;
                    cell_count++;
                    want.new_cell = 1'b1;
                    n_new++;
                end
                if (hit >= 0) begin
                    want.pixel_value = compose_pixel(hit[IDX_W-1:0]);
                    want.opaque      = 1'b1;
                end
            end
            awaited.push_back(want);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            check_field("status", 16'(want.status), 16'(got.status));
            check_field("pixel_value", 16'(want.pixel_value), 16'(got.pixel_value));
            check_field("opaque", 16'(want.opaque), 16'(got.opaque));
            check_field("transparent_index", want.transparent_index, got.transparent_index);
            check_field("new_cell", 16'(want.new_cell), 16'(got.new_cell));
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    color_cell_tracker tracker;
    bit                sender_idles;
    int                cycle_count = 0;
    int unsigned       pc_plan [PHASE_COUNT] = '{2, 3, 4, 5, 0, 6, 9, 7, 8, 8, 15};

    palette_color_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid === 1'b1) tracker.check_result(o_res);
    end

    function automatic t_req req_of(bit transp, logic [15:0] r, logic [15:0] g,
                                    logic [15:0] b, logic [15:0] idx);
        t_req q;
        q.is_transparent = transp;
        q.red            = r;
        q.green          = g;
        q.blue           = b;
        q.image_index    = idx;
        return q;
    endfunction

    function automatic t_req random_req();
        return req_of(1'($urandom()), 16'($urandom()), 16'($urandom()),
                      16'($urandom()), 16'($urandom()));
    endfunction

    // some transparent requests, many colors already in the table, some near misses, the rest fresh colors
    function automatic t_req make_request();
        t_req             q;
        int               roll;
        logic [RGB_W-1:0] rgb;
        q    = random_req();
        roll = int'($urandom_range(0, 99));
        q.is_transparent = (roll < 15);
        if (!q.is_transparent && roll < 62 && tracker.cell_count > 0) begin
            rgb = tracker.cells[$urandom_range(0, tracker.cell_count - 1)];
            if (roll >= 55) rgb ^= 48'd1 << $urandom_range(0, RGB_W - 1);
            {q.red, q.green, q.blue} = rgb;
        end
        return q;
    endfunction

    task automatic send_request(t_req r);
        if (sender_idles && $urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 300)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        while (sender_idles && $urandom_range(0, 99) < 33) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= random_req();
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(addr, data);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] data;
        tracker      = new();
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        sender_idles = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: a single cell, zero base and masks
        send_request(req_of(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(req_of(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_request(req_of(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        send_request(req_of(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(req_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_request(req_of(1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                            16'h1234));
        settle();
        write_reg(CFG_BASE_PIXEL, 64'h80);
        write_reg(CFG_PLANE_MASKS, 64'h8040_2010_0804_0201);
        write_reg(CFG_PLANE_COUNT, 64'h1);
        send_request(req_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_request(req_of(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_request(req_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0000));
        send_request(req_of(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
        settle();
        // plane count above the maximum saturates to a full table
        write_reg(CFG_BASE_PIXEL, 64'h00);
        write_reg(CFG_PLANE_MASKS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PLANE_COUNT, 64'hF);
        send_request(req_of(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
        send_request(req_of(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000));
        send_request(req_of(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
        send_request(req_of(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_request(req_of(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h8000));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            data = {$urandom(), $urandom()};
            data[7:0] = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : data[7:0];
            write_reg(CFG_BASE_PIXEL, data);
            data = {$urandom(), $urandom()};
            if (p == 0) data = '0;
            if (p == 1) data = '1;
            write_reg(CFG_PLANE_MASKS, data);
            data = {$urandom(), $urandom()};
            data[3:0] = 4'(pc_plan[p]);
            write_reg(CFG_PLANE_COUNT, data);
            if (p == 0) write_reg(CFG_SPARE, {$urandom(), $urandom()});
            sender_idles = (p != 3);
            repeat (PHASE_ITEMS) send_request(make_request());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests: %0d transparent, %0d new cells, %0d matches, %0d full",
                 tracker.n_requests, tracker.n_transparent, tracker.n_new,
                 tracker.n_match, tracker.n_full);
        $display("%0d register writes; table ended with %0d cells",
                 tracker.n_settings, tracker.cell_count);
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pca_pkg.sv
hw/rtl/pca_cell.sv
hw/rtl/palette_color_allocator.sv
hw/rtl/pca_checker.sv
verif/palette_color_allocator_test.sv
